// ----- hw/rtl/u8d_pkg.sv -----
`default_nettype none

package u8d_pkg;

    // Code point returned on every error and on an empty window
    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;

    // Continuation byte range
    localparam logic [7:0] CONT_LO = 8'h80;
    localparam logic [7:0] CONT_HI = 8'hBF;

    // Lead byte class boundaries
    localparam logic [7:0] LEAD_ASCII_MAX = 8'h7F;
    localparam logic [7:0] LEAD_BAD_MAX   = 8'hC1;
    localparam logic [7:0] LEAD_2_MAX     = 8'hDF;
    localparam logic [7:0] LEAD_3_MAX     = 8'hEF;
    localparam logic [7:0] LEAD_4_MAX     = 8'hF4;

    // Leads with a narrowed second byte range
    localparam logic [7:0] LEAD_E0 = 8'hE0;
    localparam logic [7:0] LEAD_ED = 8'hED;
    localparam logic [7:0] LEAD_F0 = 8'hF0;
    localparam logic [7:0] LEAD_F4 = 8'hF4;
    localparam logic [7:0] LO_AFTER_E0 = 8'hA0;
    localparam logic [7:0] HI_AFTER_ED = 8'h9F;
    localparam logic [7:0] LO_AFTER_F0 = 8'h90;
    localparam logic [7:0] HI_AFTER_F4 = 8'h8F;

    // Sequence lengths
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_1    = 3'd1;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic [2:0] avail;
    } t_window;

    // After lead byte classification
    typedef struct packed {
        logic       empty;
        logic       fail;     // bad lead or window too short
        logic [2:0] len;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
    } t_class;

    // After byte range checks, payload bits only
    typedef struct packed {
        logic       empty;
        logic       fail;
        logic [2:0] len;
        logic [6:0] bits0;
        logic [5:0] bits1;
        logic [5:0] bits2;
        logic [5:0] bits3;
    } t_check;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  consumed;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/u8d_if.sv -----
`default_nettype none

interface u8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [2:0] avail;

    modport source (output valid, output byte0, output byte1, output byte2,
                    output byte3, output avail, input ready);
    modport sink   (input valid, input byte0, input byte1, input byte2,
                    input byte3, input avail, output ready);
endinterface

interface u8d_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [2:0]  consumed;

    modport source (output valid, output code_point, output consumed, input ready);
    modport sink   (input valid, input code_point, input consumed, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/u8d_classify.sv -----
`default_nettype none

module u8d_classify (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire u8d_pkg::t_window i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output u8d_pkg::t_class       o_data
);

    logic            r_valid;
    u8d_pkg::t_class r_data;
    u8d_pkg::t_class n_data;
    logic [2:0]      w_avail;
    logic            w_bad_lead;

    always_comb begin
        w_avail    = (i_data.avail > u8d_pkg::LEN_4) ? u8d_pkg::LEN_4 : i_data.avail;
        w_bad_lead = 1'b0;
        n_data.lo  = u8d_pkg::CONT_LO;
        n_data.hi  = u8d_pkg::CONT_HI;
        if (i_data.byte0 <= u8d_pkg::LEAD_ASCII_MAX) begin
            n_data.len = u8d_pkg::LEN_1;
        end else if (i_data.byte0 <= u8d_pkg::LEAD_BAD_MAX) begin
            n_data.len = u8d_pkg::LEN_1;
            w_bad_lead = 1'b1;
        end else if (i_data.byte0 <= u8d_pkg::LEAD_2_MAX) begin
            n_data.len = u8d_pkg::LEN_2;
        end else if (i_data.byte0 <= u8d_pkg::LEAD_3_MAX) begin
            n_data.len = u8d_pkg::LEN_3;
            if (i_data.byte0 == u8d_pkg::LEAD_E0) n_data.lo = u8d_pkg::LO_AFTER_E0;
            if (i_data.byte0 == u8d_pkg::LEAD_ED) n_data.hi = u8d_pkg::HI_AFTER_ED;
        end else if (i_data.byte0 <= u8d_pkg::LEAD_4_MAX) begin
            n_data.len = u8d_pkg::LEN_4;
            if (i_data.byte0 == u8d_pkg::LEAD_F0) n_data.lo = u8d_pkg::LO_AFTER_F0;
            if (i_data.byte0 == u8d_pkg::LEAD_F4) n_data.hi = u8d_pkg::HI_AFTER_F4;
        end else begin
            n_data.len = u8d_pkg::LEN_1;
            w_bad_lead = 1'b1;
        end
        n_data.empty = (w_avail == u8d_pkg::LEN_NONE);
        n_data.fail  = w_bad_lead || (w_avail < n_data.len);
        n_data.byte0 = i_data.byte0;
        n_data.byte1 = i_data.byte1;
        n_data.byte2 = i_data.byte2;
        n_data.byte3 = i_data.byte3;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/u8d_check.sv -----
`default_nettype none

module u8d_check (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire u8d_pkg::t_class i_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output u8d_pkg::t_check      o_data
);

    logic            r_valid;
    u8d_pkg::t_check r_data;
    u8d_pkg::t_check n_data;
    logic            w_bad1;
    logic            w_bad2;
    logic            w_bad3;

    always_comb begin
        // second byte against the lead-specific range, later bytes plain continuation
        w_bad1 = (i_data.len >= u8d_pkg::LEN_2) &&
                 ((i_data.byte1 < i_data.lo) || (i_data.byte1 > i_data.hi));
        w_bad2 = (i_data.len >= u8d_pkg::LEN_3) &&
                 ((i_data.byte2 < u8d_pkg::CONT_LO) || (i_data.byte2 > u8d_pkg::CONT_HI));
        w_bad3 = (i_data.len == u8d_pkg::LEN_4) &&
                 ((i_data.byte3 < u8d_pkg::CONT_LO) || (i_data.byte3 > u8d_pkg::CONT_HI));
        n_data.empty = i_data.empty;
        n_data.fail  = i_data.fail || w_bad1 || w_bad2 || w_bad3;
        n_data.len   = i_data.len;
        n_data.bits0 = i_data.byte0[6:0];
        n_data.bits1 = i_data.byte1[5:0];
        n_data.bits2 = i_data.byte2[5:0];
        n_data.bits3 = i_data.byte3[5:0];
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/u8d_assemble.sv -----
`default_nettype none

module u8d_assemble (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire u8d_pkg::t_check i_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output u8d_pkg::t_result     o_data
);

    logic             r_valid;
    u8d_pkg::t_result r_data;
    u8d_pkg::t_result n_data;
    logic [20:0]      w_cp;

    always_comb begin
        case (i_data.len)
            u8d_pkg::LEN_2: w_cp = {10'd0, i_data.bits0[4:0], i_data.bits1};
            u8d_pkg::LEN_3: w_cp = {5'd0, i_data.bits0[3:0], i_data.bits1, i_data.bits2};
            u8d_pkg::LEN_4: w_cp = {i_data.bits0[2:0], i_data.bits1, i_data.bits2,
                                    i_data.bits3};
            default:        w_cp = {14'd0, i_data.bits0};
        endcase
        if (i_data.empty) begin
            n_data.code_point = u8d_pkg::CP_REPLACEMENT;
            n_data.consumed   = u8d_pkg::LEN_NONE;
        end else if (i_data.fail) begin
            n_data.code_point = u8d_pkg::CP_REPLACEMENT;
            n_data.consumed   = u8d_pkg::LEN_1;
        end else begin
            n_data.code_point = w_cp;
            n_data.consumed   = i_data.len;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/utf8_code_point_decoder.sv -----
// UTF-8 decoder: each item is a window of up to four bytes plus a count of
// valid bytes (values above four count as four); the result is the first
// code point in the window and the number of bytes it used. Overlong forms,
// surrogates, values above U+10FFFF, bad lead bytes, short windows and bad
// continuation bytes all give U+FFFD with one byte consumed; an empty window
// gives U+FFFD with zero consumed. Throughput is one item per cycle while
// the output is not stalled; each item passes through three register
// stages (lead byte classify, byte range check, code point assembly).
// Every stage has its own valid bit and takes a new item whenever it is
// empty or its content moves on, so a stall at the output only fills the
// pipe and nothing is dropped or repeated. No state is kept between items.
`default_nettype none

module utf8_code_point_decoder (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    u8d_in_if.sink     i_in,
    u8d_out_if.source  o_out
);

    u8d_pkg::t_window w_window;
    u8d_pkg::t_class  w_s1_data;
    u8d_pkg::t_check  w_s2_data;
    u8d_pkg::t_result w_s3_data;
    logic             w_s1_valid;
    logic             w_s1_ready;
    logic             w_s2_valid;
    logic             w_s2_ready;

    assign w_window.byte0 = i_in.byte0;
    assign w_window.byte1 = i_in.byte1;
    assign w_window.byte2 = i_in.byte2;
    assign w_window.byte3 = i_in.byte3;
    assign w_window.avail = i_in.avail;

    // stage 1: lead byte -> length, second byte range, short window
    u8d_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_data  (w_window),
        .o_valid (w_s1_valid),
        .i_ready (w_s1_ready),
        .o_data  (w_s1_data)
    );

    // stage 2: range checks on the trailing bytes, folded into one fail flag
    u8d_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .o_ready (w_s1_ready),
        .i_data  (w_s1_data),
        .o_valid (w_s2_valid),
        .i_ready (w_s2_ready),
        .o_data  (w_s2_data)
    );

    // stage 3: payload bits -> code point, doubles as the output register
    u8d_assemble u_assemble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_valid),
        .o_ready (w_s2_ready),
        .i_data  (w_s2_data),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (w_s3_data)
    );

    assign o_out.code_point = w_s3_data.code_point;
    assign o_out.consumed   = w_s3_data.consumed;

    // an empty pipe always takes input
    a_empty_pipe_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_s1_valid && !w_s2_valid && !o_out.valid) |-> i_in.ready)
        else $error("empty pipeline not ready for input");

    // decoded values are scalar values only
    a_cp_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.code_point <= 21'h10FFFF) &&
                         !((o_out.code_point >= 21'h00D800) &&
                           (o_out.code_point <= 21'h00DFFF))))
        else $error("code point outside the scalar value range");

    // byte count in range, zero only with the replacement character
    a_consumed_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.consumed <= u8d_pkg::LEN_4) &&
                         ((o_out.consumed != u8d_pkg::LEN_NONE) ||
                          (o_out.code_point == u8d_pkg::CP_REPLACEMENT))))
        else $error("bad consumed count");

endmodule

`default_nettype wire
